// ===== rtl/core/cfa_pkg.sv =====
package cfa_pkg;

    localparam int MaxEntries = 16;
    localparam int AddrBits   = 16;
    localparam int LenBits    = AddrBits + 1;
    localparam int IdxBits    = $clog2(MaxEntries);
    localparam int CntBits    = $clog2(MaxEntries + 1);

    typedef logic [AddrBits-1:0] addr_t;
    typedef logic [LenBits-1:0]  len_t;
    typedef logic [IdxBits-1:0]  idx_t;
    typedef logic [CntBits-1:0]  cnt_t;

    typedef enum logic [1:0] {
        ST_OK         = 2'd0,
        ST_NO_FIT     = 2'd1,
        ST_NOT_FOUND  = 2'd2,
        ST_TABLE_FULL = 2'd3
    } status_t;

    typedef enum logic [1:0] {
        POL_FIRST = 2'd0,
        POL_BEST  = 2'd1,
        POL_WORST = 2'd2
    } policy_t;

    localparam logic REQ_ALLOC = 1'b0;
    localparam logic REQ_FREE  = 1'b1;

    localparam logic CFG_CAPACITY = 1'b0;
    localparam logic CFG_POLICY   = 1'b1;

    typedef enum logic [2:0] {
        S_IDLE,
        S_SCAN,
        S_DECIDE,
        S_APPLY,
        S_DONE
    } state_t;

    // Per-cell hole operation, broadcast to the row
    typedef enum logic [2:0] {
        HOP_NONE,
        HOP_INIT,
        HOP_REMOVE,
        HOP_INSERT,
        HOP_WRITE
    } hole_op_t;

    typedef struct packed {
        hole_op_t op;
        idx_t     k;
        cnt_t     n;
        addr_t    start;
        len_t     len;
    } hole_cmd_t;

    typedef struct packed {
        logic  vld;
        addr_t start;
        len_t  len;
    } hole_t;

endpackage

// ===== rtl/core/cfa_if.sv =====
interface cfa_req_if;
    logic        valid;
    logic        ready;
    logic        req_type;
    logic [15:0] alloc_size;
    logic [15:0] location;
    modport source (output valid, req_type, alloc_size, location, input ready);
    modport sink (input valid, req_type, alloc_size, location, output ready);
endinterface

interface cfa_rsp_if;
    logic        valid;
    logic        ready;
    logic [15:0] address;
    logic [1:0]  status;
    modport source (output valid, address, status, input ready);
    modport sink (input valid, address, status, output ready);
endinterface

// ===== rtl/core/cfa_hole_cell.sv =====
module cfa_hole_cell (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              first,
    input  cfa_pkg::idx_t     pos,
    input  cfa_pkg::hole_cmd_t cmd,
    input  cfa_pkg::hole_t    left_in,
    input  cfa_pkg::hole_t    right_in,
    output cfa_pkg::hole_t    hole
);
    import cfa_pkg::*;

    hole_t hole_reg;
    hole_t hole_next;
    cnt_t  p;

    assign p    = cnt_t'(pos);
    assign hole = hole_reg;

    // Shift, overwrite or clear this slot
    always_comb
    begin
        hole_next = hole_reg;
        case (cmd.op)
            HOP_INIT:
            begin
                hole_next.vld   = first && (cmd.len != '0);
                hole_next.start = '0;
                hole_next.len   = cmd.len;
            end
            HOP_REMOVE:
            begin
                if (pos >= cmd.k && p + 1'b1 < cmd.n)
                begin
                    hole_next.start = right_in.start;
                    hole_next.len   = right_in.len;
                end
                if (p + 1'b1 == cmd.n)
                    hole_next.vld = 1'b0;
            end
            HOP_INSERT:
            begin
                if (pos > cmd.k && p <= cmd.n)
                begin
                    hole_next.start = left_in.start;
                    hole_next.len   = left_in.len;
                end
                if (pos == cmd.k)
                begin
                    hole_next.start = cmd.start;
                    hole_next.len   = cmd.len;
                end
                if (p == cmd.n)
                    hole_next.vld = 1'b1;
            end
            HOP_WRITE:
            begin
                if (pos == cmd.k)
                begin
                    hole_next.start = cmd.start;
                    hole_next.len   = cmd.len;
                end
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hole_reg.vld   <= first;
            hole_reg.start <= '0;
            hole_reg.len   <= first ? len_t'(17'd65535) : '0;
        end
        else
        begin
            hole_reg <= hole_next;
        end
    end
endmodule

// ===== rtl/core/cfa_hole_row.sv =====
module cfa_hole_row (
    input  logic               clk,
    input  logic               rst_n,
    input  cfa_pkg::hole_cmd_t cmd,
    output cfa_pkg::hole_t     holes [cfa_pkg::MaxEntries]
);
    import cfa_pkg::*;

    hole_t nil;
    assign nil = '0;

    for (genvar i = 0; i < MaxEntries; i++)
    begin : g_cell
        cfa_hole_cell u_cell (
            .clk      (clk),
            .rst_n    (rst_n),
            .first    (i == 0),
            .pos      (idx_t'(i)),
            .cmd      (cmd),
            .left_in  ((i == 0) ? nil : holes[(i == 0) ? 0 : i - 1]),
            .right_in ((i == MaxEntries - 1) ? nil
                       : holes[(i == MaxEntries - 1) ? i : i + 1]),
            .hole     (holes[i])
        );
    end
endmodule

// ===== rtl/core/contiguous_fit_allocator_top.sv =====
// A request passes through the scan, decide and apply states; its result is then registered as valid.
// A new request is accepted only in idle, so the next one is taken only after the last has left apply.
// A result that is still waiting holds the next request in its apply step.
// The hole search is a registered pass over the row, reduced by a four-level tree.
// Reset: one hole [0, 65535), no allocations, first fit policy.
module contiguous_fit_allocator_top (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_we,
    input  logic        cfg_index,
    input  logic [15:0] cfg_data,
    cfa_req_if.sink     req,
    cfa_rsp_if.source   rsp
);
    import cfa_pkg::*;

    state_t    state_reg, state_next;
    logic [1:0] policy_reg;
    logic       rtype_reg;
    len_t       size_reg;
    addr_t      loc_reg;
    logic [MaxEntries-1:0] bvld_reg;
    addr_t      bstart_reg [MaxEntries];
    len_t       blen_reg [MaxEntries];
    hole_t      holes [MaxEntries];
    hole_cmd_t  cmd;
    logic       rsp_vld_reg;
    addr_t      rsp_addr_reg;
    status_t    rsp_st_reg;

    // Scan results
    cnt_t  n_reg;
    logic  pick_ok_reg;
    idx_t  pick_reg;
    logic  slot_ok_reg;
    idx_t  slot_reg;
    logic  bfound_reg;
    idx_t  bslot_reg;
    cnt_t  k_reg;

    cnt_t  n_c;
    logic  pick_ok_c;
    idx_t  pick_c;
    logic  slot_ok_c;
    idx_t  slot_c;
    logic  bfound_c;
    idx_t  bslot_c;
    cnt_t  k_c;

    // Hole choice tree, leaves in address order
    logic  t_ok  [2*MaxEntries-1];
    idx_t  t_idx [2*MaxEntries-1];
    len_t  t_len [2*MaxEntries-1];
    logic  take_r;

    // Decide results
    status_t st_reg;
    hole_cmd_t dcmd_reg;
    addr_t   daddr_reg;

    assign req.ready   = (state_reg == S_IDLE) && !cfg_we;
    assign rsp.valid   = rsp_vld_reg;
    assign rsp.address = rsp_addr_reg;
    assign rsp.status  = rsp_st_reg;

    // Scan the holes and block slots
    always_comb
    begin
        n_c = '0; pick_ok_c = 1'b0; pick_c = '0; take_r = 1'b0;
        slot_ok_c = 1'b0; slot_c = '0; bfound_c = 1'b0; bslot_c = '0; k_c = '0;
        for (int i = 0; i < MaxEntries; i++)
        begin
            if (holes[i].vld && n_c == cnt_t'(i))
                n_c = cnt_t'(i + 1);
        end
        for (int i = 0; i < MaxEntries; i++)
        begin
            t_ok[MaxEntries-1+i]  = holes[i].vld && holes[i].len >= size_reg;
            t_idx[MaxEntries-1+i] = idx_t'(i);
            t_len[MaxEntries-1+i] = holes[i].len;
            if (cnt_t'(i) < n_c && holes[i].start < loc_reg)
                k_c = cnt_t'(i + 1);
        end
        // Pair up neighbors; the right side wins ties under best fit only
        for (int j = MaxEntries - 2; j >= 0; j--)
        begin
            take_r = t_ok[2*j+2] && (!t_ok[2*j+1]
                     || (policy_reg == POL_BEST && t_len[2*j+2] <= t_len[2*j+1])
                     || (policy_reg == POL_WORST && t_len[2*j+2] > t_len[2*j+1]));
            t_ok[j]  = t_ok[2*j+1] || t_ok[2*j+2];
            t_idx[j] = take_r ? t_idx[2*j+2] : t_idx[2*j+1];
            t_len[j] = take_r ? t_len[2*j+2] : t_len[2*j+1];
        end
        pick_ok_c = t_ok[0];
        pick_c    = t_idx[0];
        for (int i = MaxEntries - 1; i >= 0; i--)
        begin
            if (!bvld_reg[i])
            begin
                slot_ok_c = 1'b1; slot_c = idx_t'(i);
            end
            if (bvld_reg[i] && bstart_reg[i] == loc_reg)
            begin
                bfound_c = 1'b1; bslot_c = idx_t'(i);
            end
        end
    end

    // Decide the outcome and hole update
    status_t   st_c;
    hole_cmd_t dcmd_c;
    len_t      psz;
    len_t      lsum;
    logic      lft, rgt;
    idx_t      km1, kx;
    always_comb
    begin
        st_c = ST_OK;
        dcmd_c = '0;
        dcmd_c.op = HOP_NONE;
        dcmd_c.n = n_reg;
        km1 = idx_t'(k_reg - 1'b1);
        kx  = idx_t'(k_reg);
        psz = blen_reg[bslot_reg];
        lsum = len_t'(holes[km1].start) + holes[km1].len;
        lft = (k_reg != '0) && (lsum == len_t'(loc_reg));
        rgt = (k_reg < n_reg) && (len_t'(holes[kx].start) == len_t'(loc_reg) + psz);
        if (rtype_reg == REQ_ALLOC)
        begin
            if (size_reg == '0 || policy_reg == 2'd3 || !pick_ok_reg)
                st_c = ST_NO_FIT;
            else if (!slot_ok_reg)
                st_c = ST_TABLE_FULL;
            else if (holes[pick_reg].len == size_reg)
            begin
                dcmd_c.op = HOP_REMOVE; dcmd_c.k = pick_reg;
            end
            else
            begin
                dcmd_c.op = HOP_WRITE; dcmd_c.k = pick_reg;
                dcmd_c.start = holes[pick_reg].start + addr_t'(size_reg);
                dcmd_c.len = holes[pick_reg].len - size_reg;
            end
        end
        else if (!bfound_reg)
            st_c = ST_NOT_FOUND;
        else if (lft && rgt)
        begin
            // Merge into left; the right hole drops out at the next step
            dcmd_c.op = HOP_WRITE; dcmd_c.k = km1;
            dcmd_c.start = holes[km1].start;
            dcmd_c.len = holes[km1].len + psz + holes[kx].len;
        end
        else if (lft)
        begin
            dcmd_c.op = HOP_WRITE; dcmd_c.k = km1;
            dcmd_c.start = holes[km1].start;
            dcmd_c.len = holes[km1].len + psz;
        end
        else if (rgt)
        begin
            dcmd_c.op = HOP_WRITE; dcmd_c.k = kx;
            dcmd_c.start = loc_reg;
            dcmd_c.len = holes[kx].len + psz;
        end
        else if (n_reg >= cnt_t'(MaxEntries))
            st_c = ST_TABLE_FULL;
        else
        begin
            dcmd_c.op = HOP_INSERT; dcmd_c.k = kx;
            dcmd_c.start = loc_reg; dcmd_c.len = psz;
        end
    end

    logic merge_both_reg;

    // Drive the hole row
    always_comb
    begin
        cmd = '0;
        cmd.op = HOP_NONE;
        if (cfg_we && cfg_index == CFG_CAPACITY && state_reg == S_IDLE)
        begin
            cmd.op = HOP_INIT;
            cmd.len = len_t'(cfg_data);
        end
        else if (state_reg == S_DECIDE && st_c == ST_OK)
            cmd = dcmd_c;
        else if (state_reg == S_APPLY && merge_both_reg)
        begin
            cmd.op = HOP_REMOVE;
            cmd.k  = dcmd_reg.k + 1'b1;
            cmd.n  = n_reg;
        end
    end

    cfa_hole_row u_row (
        .clk   (clk),
        .rst_n (rst_n),
        .cmd   (cmd),
        .holes (holes)
    );

    // Next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:   if (req.valid && req.ready) state_next = S_SCAN;
            S_SCAN:   state_next = S_DECIDE;
            S_DECIDE: state_next = S_APPLY;
            S_APPLY:  if (!rsp_vld_reg || rsp.ready) state_next = S_IDLE;
            default:  state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            policy_reg     <= '0;
            bvld_reg       <= '0;
            rsp_vld_reg    <= 1'b0;
            merge_both_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (cfg_we && cfg_index == CFG_POLICY)
                policy_reg <= cfg_data[1:0];
            if (cfg_we && cfg_index == CFG_CAPACITY)
                bvld_reg <= '0;
            else if (state_reg == S_DECIDE && st_c == ST_OK)
            begin
                if (rtype_reg == REQ_ALLOC)
                    bvld_reg[slot_reg] <= 1'b1;
                else
                    bvld_reg[bslot_reg] <= 1'b0;
            end
            merge_both_reg <= (state_reg == S_DECIDE) && (st_c == ST_OK)
                              && rtype_reg == REQ_FREE && lft && rgt;
            if (state_reg == S_APPLY && state_next == S_IDLE)
                rsp_vld_reg <= 1'b1;
            else if (rsp.ready)
                rsp_vld_reg <= 1'b0;
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        if (req.valid && req.ready)
        begin
            rtype_reg <= req.req_type;
            size_reg  <= len_t'(req.alloc_size);
            loc_reg   <= req.location;
        end
        if (state_reg == S_SCAN)
        begin
            n_reg <= n_c; pick_ok_reg <= pick_ok_c; pick_reg <= pick_c;
            slot_ok_reg <= slot_ok_c; slot_reg <= slot_c;
            bfound_reg <= bfound_c; bslot_reg <= bslot_c; k_reg <= k_c;
        end
        if (state_reg == S_DECIDE)
        begin
            st_reg    <= st_c;
            dcmd_reg  <= dcmd_c;
            daddr_reg <= (st_c == ST_OK && rtype_reg == REQ_ALLOC)
                         ? holes[pick_reg].start : '0;
            if (st_c == ST_OK && rtype_reg == REQ_ALLOC)
            begin
                bstart_reg[slot_reg] <= holes[pick_reg].start;
                blen_reg[slot_reg]   <= size_reg;
            end
        end
        if (state_reg == S_APPLY && state_next == S_IDLE)
        begin
            rsp_addr_reg <= daddr_reg;
            rsp_st_reg   <= st_reg;
        end
    end
endmodule
